FILE: hdl/dse_pkg.sv
// Shared constants and types for the diversity swap evaluator.
`timescale 1ns / 1ps
package dse_pkg;
	localparam int ELEMENTS     = 256;
	localparam int SELECTED_MAX = 64;
	localparam int DIST_BITS    = 16;
	localparam int EL_W  = $clog2(ELEMENTS);
	localparam int POS_W = $clog2(SELECTED_MAX);
	localparam int CNT_W = $clog2(SELECTED_MAX + 1);
	localparam int DADDR_W = 2 * EL_W;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_ADD  = 2'd1;
	localparam logic [1:0] CMD_SWAP = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BADP = 2'd2;

	// Memory access request from the sequencer to the state memories.
	typedef struct packed {
		logic               dist_we;
		logic [DADDR_W-1:0] dist_waddr;
		logic [DIST_BITS-1:0] dist_wdata;
		logic               dist_re;
		logic [DADDR_W-1:0] dist_raddr;
		logic               mem_we;
		logic [POS_W-1:0]   mem_waddr;
		logic [EL_W-1:0]    mem_wid;
		logic [31:0]        mem_wcontrib;
		logic [POS_W-1:0]   mem_raddr;
	} dse_mreq_t;
endpackage

FILE: hdl/diversity_swap_evaluator.sv
// Top level of the diversity swap evaluator: command sequencer over the state memories.
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid/tready      cmd, index_a, index_b, position, distance, accept_floor
// m_axis    out  tvalid/tready      delta, accepted, total, selected_size, status
// A load, an unknown command, an add on a full selection and a swap with a bad position go
// straight to the result. In an add or a swap every member costs a member-memory read, a
// distance read and an accumulate step, and both memories give registered read data. An
// applied swap walks the members a second time to update them, and that update walk reads
// two distances for every member but the leaving one.
// One command is worked on at a time; the next beat is taken only once the previous result
// has left the output register. Reset clears the count, the total and the control state;
// the memories are not cleared. A stalled output holds its result and keeps the input stalled.
module diversity_swap_evaluator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [1:0] cmd, [9:2] index_a, [17:10] index_b, [23:18] position,
	// [39:24] distance, [71:40] accept_floor
	input  logic [71:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] delta, [32] accepted, [64:33] total, [71:65] selected_size, [73:72] status
	output logic [79:0]  m_axis_tdata
);
	import dse_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0; // waiting for a command
	localparam logic [2:0] S_RDM  = 3'd1; // member read issued
	localparam logic [2:0] S_RDD  = 3'd2; // distance read issued
	localparam logic [2:0] S_ACC  = 3'd3; // distance returned, accumulate/update
	localparam logic [2:0] S_DEC  = 3'd4; // swap decision
	localparam logic [2:0] S_FIN  = 3'd5; // final write and result
	localparam logic [2:0] S_OUT  = 3'd6; // result waits for the output register

	logic [2:0] state_q;
	logic [1:0] cmd_q;
	logic [EL_W-1:0] a_q;
	logic [POS_W-1:0] pos_q;
	logic signed [31:0] floor_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0] total_q;
	logic [CNT_W-1:0] j_q;
	logic pass_q;       // swap: 0 evaluate, 1 update
	logic [EL_W-1:0] old_q, mid_q;
	logic [31:0] mcon_q, lcon_q, sum_q, dold_q;
	logic phase_q;      // update pass: 0 old-distance read, 1 new-distance read
	logic [1:0] status_q;
	logic [31:0] delta_q;
	logic acc_q;

	dse_mreq_t req;
	logic [DIST_BITS-1:0] drd;
	logic [EL_W-1:0] mrid;
	logic [31:0] mrcon;

	dse_mem u_mem (.clk(clk), .req(req), .dist_rdata(drd), .mem_rid(mrid),
		.mem_rcontrib(mrcon));

	logic [1:0] in_cmd;
	logic [EL_W-1:0] in_a, in_b;
	assign in_cmd = s_axis_tdata[1:0];
	assign in_a = s_axis_tdata[9:2];
	assign in_b = s_axis_tdata[17:10];

	// Pair address of (x, y), with the smaller id in the upper bits.
	function automatic logic [DADDR_W-1:0] paddr(input logic [EL_W-1:0] x,
		input logic [EL_W-1:0] y);
		if (x < y) return {x, y};
		return {y, x};
	endfunction

	logic [EL_W-1:0] dy;
	logic dzero_q;
	logic [31:0] dval;
	assign dy = (pass_q && !phase_q) ? old_q : a_q;
	assign dval = dzero_q ? 32'd0 : {{(32-DIST_BITS){1'b0}}, drd};

	logic [31:0] delta_c;
	assign delta_c = sum_q;
	logic take_c;
	assign take_c = ($signed(delta_c) > 0) || ($signed(delta_c) > floor_q);

	logic last_c;
	assign last_c = (j_q + 1'b1) >= cnt_q;
	logic skip_c;
	assign skip_c = (cmd_q == CMD_SWAP) && (j_q[POS_W-1:0] == pos_q);

	assign s_axis_tready = (state_q == S_IDLE) && !m_axis_tvalid;

	always_comb begin
		req = '0;
		req.mem_raddr = j_q[POS_W-1:0];
		// The member id arrives from the member memory in the same cycle the
		// distance read is issued.
		req.dist_raddr = paddr(mrid, dy);
		if (state_q == S_IDLE && s_axis_tvalid && s_axis_tready) begin
			req.mem_raddr = (in_cmd == CMD_SWAP) ? s_axis_tdata[23:18] : '0;
			if (in_cmd == CMD_LOAD && in_a != in_b) begin
				req.dist_we = 1'b1;
				req.dist_waddr = paddr(in_a, in_b);
				req.dist_wdata = s_axis_tdata[39:24];
			end
		end
		if (state_q == S_RDD) req.dist_re = 1'b1;
		if (state_q == S_ACC && cmd_q != CMD_SWAP) begin
			req.mem_we = 1'b1;
			req.mem_waddr = j_q[POS_W-1:0];
			req.mem_wid = mid_q;
			req.mem_wcontrib = mcon_q + dval;
		end
		if (state_q == S_ACC && cmd_q == CMD_SWAP && pass_q && phase_q) begin
			req.mem_we = 1'b1;
			req.mem_waddr = j_q[POS_W-1:0];
			req.mem_wid = mid_q;
			req.mem_wcontrib = mcon_q - dold_q + dval;
		end
		if (state_q == S_FIN) begin
			req.mem_we = 1'b1;
			req.mem_waddr = (cmd_q == CMD_SWAP) ? pos_q : cnt_q[POS_W-1:0];
			req.mem_wid = a_q;
			req.mem_wcontrib = (cmd_q == CMD_SWAP) ? lcon_q + delta_q : sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			total_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && state_q != S_OUT) m_axis_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						cmd_q <= in_cmd;
						a_q <= in_a;
						pos_q <= s_axis_tdata[23:18];
						floor_q <= s_axis_tdata[71:40];
						j_q <= '0;
						pass_q <= 1'b0;
						phase_q <= 1'b0;
						sum_q <= '0;
						status_q <= ST_OK;
						delta_q <= '0;
						acc_q <= 1'b0;
						state_q <= S_OUT;
						if (in_cmd == CMD_ADD) begin
							if (cnt_q >= CNT_W'(SELECTED_MAX)) status_q <= ST_FULL;
							else if (cnt_q == '0) state_q <= S_FIN;
							else state_q <= S_RDM;
						end else if (in_cmd == CMD_SWAP) begin
							if ({1'b0, s_axis_tdata[23:18]} >= cnt_q) status_q <= ST_BADP;
							else state_q <= S_RDM;
						end
					end
				end
				S_RDM: begin
					// On the first cycle of a swap the leaving slot is captured before the walk.
					if (cmd_q == CMD_SWAP && !pass_q && j_q == '0 && !phase_q) begin
						phase_q <= 1'b1;
						old_q <= mrid;
						lcon_q <= mrcon;
						sum_q <= 32'd0 - mrcon;
					end else begin
						if (pass_q) phase_q <= 1'b0;
						state_q <= S_RDD;
					end
				end
				S_RDD: begin
					mid_q <= mrid;
					if (!(cmd_q == CMD_SWAP && pass_q && phase_q)) mcon_q <= mrcon;
					dzero_q <= (mrid == dy);
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (cmd_q == CMD_SWAP && pass_q && !phase_q && !skip_c) begin
						dold_q <= dval;
						phase_q <= 1'b1;
						state_q <= S_RDD;
					end else begin
						if (cmd_q != CMD_SWAP) sum_q <= sum_q + dval;
						else if (!pass_q && !skip_c) sum_q <= sum_q + dval;
						phase_q <= 1'b0;
						j_q <= j_q + 1'b1;
						if (last_c) begin
							if (cmd_q != CMD_SWAP) state_q <= S_FIN;
							else if (!pass_q) state_q <= S_DEC;
							else state_q <= S_FIN;
						end else begin
							state_q <= S_RDM;
						end
					end
				end
				S_DEC: begin
					delta_q <= delta_c;
					j_q <= '0;
					if (take_c) begin
						acc_q <= 1'b1;
						pass_q <= 1'b1;
						phase_q <= 1'b0;
						state_q <= S_RDM;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_FIN: begin
					if (cmd_q == CMD_SWAP) total_q <= total_q + delta_q;
					else begin
						total_q <= total_q + sum_q;
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata <= {6'd0, status_q, 7'(cnt_q), total_q, acc_q, delta_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The final swap write adds delta to the leaving contribution held in lcon_q, since
	// mcon_q is reloaded for every member of the update pass.

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(SELECTED_MAX)) else $error("count overflow");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEC) |-> ({1'b0, pos_q} < cnt_q)) else $error("bad swap slot");
endmodule

FILE: hdl/dse_mem.sv
// Distance store and member memory, each with registered read data.
`timescale 1ns / 1ps
module dse_mem (
	input  logic                         clk,
	input  dse_pkg::dse_mreq_t           req,
	output logic [dse_pkg::DIST_BITS-1:0] dist_rdata,
	output logic [dse_pkg::EL_W-1:0]      mem_rid,
	output logic [31:0]                   mem_rcontrib
);
	import dse_pkg::*;
	logic [DIST_BITS-1:0] dist_ram [0:(1<<DADDR_W)-1];
	logic [EL_W+31:0]     mem_ram [0:SELECTED_MAX-1];

	always_ff @(posedge clk) begin
		if (req.dist_we) dist_ram[req.dist_waddr] <= req.dist_wdata;
		if (req.dist_re) dist_rdata <= dist_ram[req.dist_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.mem_we) mem_ram[req.mem_waddr] <= {req.mem_wid, req.mem_wcontrib};
		{mem_rid, mem_rcontrib} <= mem_ram[req.mem_raddr];
	end
endmodule

FILE: sim/diversity_swap_evaluator_tb.sv
// Self-checking testbench for the diversity swap evaluator stream block.
`timescale 1ns / 1ps
module diversity_swap_evaluator_tb;
	import dse_pkg::*;

	localparam int LIMIT = 6000000;

	// One command beat and one result beat as the block packs them.
	typedef struct packed {
		logic signed [31:0] floor_v;
		logic [15:0]        distance;
		logic [5:0]         pos;
		logic [7:0]         idx_b;
		logic [7:0]         idx_a;
		logic [1:0]         cmd;
	} cmd_beat_t;

	typedef struct packed {
		logic [5:0]         pad;
		logic [1:0]         status;
		logic [6:0]         sel_size;
		logic [31:0]        total;
		logic               accepted;
		logic signed [31:0] delta;
	} res_beat_t;

	// Scoreboard: shadow copy of the selection and the distance table.
	class diversity_scoreboard;
		logic [15:0] dist_tab [int];
		logic [7:0]  ids [SELECTED_MAX];
		logic [31:0] contrib [SELECTED_MAX];
		int          count;
		logic [31:0] total = '0;
		res_beat_t   pending [$];
		int          errors;

		function logic [31:0] pair(logic [7:0] x, logic [7:0] y);
			int lo;
			int hi;
			lo = (x < y) ? x : y;
			hi = (x < y) ? y : x;
			if (x == y) return 0;
			if (!dist_tab.exists(lo * ELEMENTS + hi)) return 0;
			return dist_tab[lo * ELEMENTS + hi];
		endfunction

		function void note_command(cmd_beat_t c);
			res_beat_t r;
			logic [31:0] d;
			logic [31:0] sum;
			logic [7:0]  old;
			r = '0;
			if (c.cmd == CMD_LOAD) begin
				if (c.idx_a != c.idx_b)
					dist_tab[((c.idx_a < c.idx_b) ? c.idx_a : c.idx_b) * ELEMENTS +
						((c.idx_a < c.idx_b) ? c.idx_b : c.idx_a)] = c.distance;
			end else if (c.cmd == CMD_ADD) begin
				if (count >= SELECTED_MAX) begin
					r.status = ST_FULL;
				end else begin
					sum = 0;
					for (int j = 0; j < count; j++) begin
						d = pair(ids[j], c.idx_a);
						contrib[j] += d;
						sum += d;
					end
					ids[count] = c.idx_a;
					contrib[count] = sum;
					count++;
					total += sum;
				end
			end else if (c.cmd == CMD_SWAP) begin
				if (c.pos >= count) begin
					r.status = ST_BADP;
				end else begin
					d = 32'd0 - contrib[c.pos];
					for (int j = 0; j < count; j++)
						if (j != c.pos) d += pair(c.idx_a, ids[j]);
					r.delta = d;
					if ($signed(d) > 0 || $signed(d) > c.floor_v) begin
						r.accepted = 1'b1;
						old = ids[c.pos];
						for (int j = 0; j < count; j++)
							if (j != c.pos)
								contrib[j] = contrib[j] - pair(ids[j], old)
									+ pair(ids[j], c.idx_a);
						contrib[c.pos] += d;
						ids[c.pos] = c.idx_a;
						total += d;
					end
				end
			end
			r.total = total;
			r.sel_size = count[6:0];
			pending = {pending, r};
		endfunction

		function void check_result(res_beat_t a);
			res_beat_t e;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected: %h", a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.delta !== e.delta) begin
				$error("delta expected %0d actual %0d", e.delta, a.delta); errors++;
			end
			if (a.accepted !== e.accepted) begin
				$error("accepted expected %0d actual %0d", e.accepted, a.accepted); errors++;
			end
			if (a.total !== e.total) begin
				$error("total expected %0d actual %0d", e.total, a.total); errors++;
			end
			if (a.sel_size !== e.sel_size) begin
				$error("selected_size expected %0d actual %0d", e.sel_size, a.sel_size);
				errors++;
			end
			if (a.status !== e.status) begin
				$error("status expected %0d actual %0d", e.status, a.status); errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;

	diversity_scoreboard sb = new();
	int  cycles = 0;
	bit  hold_off = 0;      // long receiver stall requested by the stimulus
	bit  stall_mode = 0;    // receiver stalls at random when set

	// Every pair among the first PAIR_N elements gets a distance loaded before
	// any add or swap touches it, so no unwritten entry is ever used.
	localparam int PAIR_N = 24;

	always #5 clk = ~clk;

	diversity_swap_evaluator dut (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: checks every result beat and stalls on its own pattern.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(res_beat_t'(m_axis_tdata));
		if (hold_off)
			m_axis_tready <= 1'b0;
		else if (stall_mode)
			m_axis_tready <= ($urandom_range(0, 3) != 0);
		else
			m_axis_tready <= 1'b1;
	end

	// Sends one command beat; idle cycles first when a gap is given.
	task automatic send(input cmd_beat_t c, input int gap);
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_command(c);
	endtask

	function automatic cmd_beat_t make(logic [1:0] k, logic [7:0] a, logic [7:0] b,
		logic [5:0] p, logic [15:0] d, logic [31:0] f);
		cmd_beat_t c;
		c.cmd = k; c.idx_a = a; c.idx_b = b; c.pos = p; c.distance = d; c.floor_v = f;
		return c;
	endfunction

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Random beat; element ids stay below PAIR_N, except on loads and unknown commands.
	task automatic random_beat(input int gap);
		int r;
		logic [31:0] f;
		r = $urandom_range(0, 99);
		f = ($urandom_range(0, 3) == 0) ? 32'd0 : -$urandom_range(0, 200000);
		if ($urandom_range(0, 30) == 0) f = 32'h8000_0000;
		if (r < 8)
			send(make(CMD_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom), gap);
		else if (r < 15)
			send(make(CMD_ADD, $urandom_range(0, PAIR_N - 1), $urandom, $urandom,
				$urandom, $urandom), gap);
		else if (r < 18)
			send(make(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom), gap);
		else
			send(make(CMD_SWAP, $urandom_range(0, PAIR_N - 1), $urandom, $urandom,
				$urandom, f), gap);
	endtask

	initial begin
		int burst;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fill the distance table for the working elements, with
		// extreme values, swapped row and column, and ignored self loads.
		for (int i = 0; i < PAIR_N; i++)
			for (int j = i + 1; j < PAIR_N; j++)
				send(make(CMD_LOAD, (i + j) % 2 ? j : i, (i + j) % 2 ? i : j, 6'h3f,
					(i == 0) ? 16'hffff : (j == PAIR_N - 1) ? 16'd0 : $urandom,
					32'hffff_ffff), 0);
		send(make(CMD_LOAD, 8'd5, 8'd5, 0, 16'h1234, 0), 0);
		send(make(CMD_LOAD, 8'd255, 8'd254, 0, 16'hffff, 0), 0);
		send(make(CMD_SWAP, 8'd1, 0, 6'd0, 0, 0), 0);                // bad position
		send(make(CMD_ADD, 8'd0, 0, 0, 0, 0), 0);
		send(make(CMD_ADD, 8'd0, 0, 0, 0, 0), 0);                    // duplicate id
		send(make(CMD_ADD, 8'd1, 8'hff, 6'h3f, 16'hffff, 32'h8000_0000), 0);
		send(make(CMD_ADD, 8'd23, 0, 0, 0, 0), 0);                   // zero to all but id 0
		send(make(CMD_SWAP, 8'd2, 0, 6'd0, 0, 32'h8000_0000), 0);
		send(make(CMD_SWAP, 8'd3, 0, 6'd1, 0, 32'd0), 0);
		send(make(CMD_SWAP, 8'd1, 0, 6'd2, 0, 32'd0), 0);            // incoming already in
		send(make(CMD_SWAP, 8'd4, 0, 6'd63, 0, 32'd0), 0);
		send(make(2'd3, 8'hff, 8'hff, 6'h3f, 16'hffff, 32'hffff_ffff), 0);
		drain();

		// Fill to capacity and try adds while full.
		for (int i = 0; i < SELECTED_MAX; i++)
			send(make(CMD_ADD, $urandom_range(0, PAIR_N - 1), 0, 0, 0, 0), 0);
		send(make(CMD_ADD, 8'd7, 0, 0, 0, 0), 0);
		send(make(CMD_SWAP, 8'd9, 0, 6'd63, 0, 32'h8000_0000), 0);

		// Long receiver hold-off while the sender keeps offering beats.
		fork
			begin
				hold_off = 1;
				repeat (2000) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 10; i++) random_beat(0);
		join
		// Sender pauses until every expected result is in.
		drain();

		// Random part in bursts, with and without receiver stalls.
		for (int n = 0; n < 1150; n += burst) begin
			burst = $urandom_range(1, 40);
			stall_mode = $urandom_range(0, 2) != 0;
			for (int i = 0; i < burst; i++)
				random_beat((i == 0) ? $urandom_range(0, 30) : $urandom_range(0, 1));
		end

		drain();
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
